>>> hw/rtl/image_to_ground_projection_defines.svh
// Assertion macros shared by the image-to-ground projection RTL.
`ifndef IMAGE_TO_GROUND_PROJECTION_DEFINES_SVH
`define IMAGE_TO_GROUND_PROJECTION_DEFINES_SVH

// Clocked check, suspended while reset is asserted.
`define IGP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("igp check failed");

// Clocked check that also holds during reset.
`define IGP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("igp check failed");

`endif

>>> hw/rtl/igp_pkg.sv
// Package: constants and register codes of the image-to-ground projection.
package igp_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_BITS  = 32;
  localparam int CFG_IDX_BITS = 3;
  // Quotient bits produced by the divider: 32 result bits plus one guard bit.
  localparam int QUOT_BITS  = 33;

  localparam logic [COEF_BITS-1:0] COEF_W_CONST_RST = 32'h0001_0000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_X_U     = 3'd0,
    REG_X_V     = 3'd1,
    REG_X_CONST = 3'd2,
    REG_Y_U     = 3'd3,
    REG_Y_V     = 3'd4,
    REG_Y_CONST = 3'd5,
    REG_W_V     = 3'd6,
    REG_W_CONST = 3'd7
  } cfg_reg_e;

endpackage

>>> hw/rtl/image_to_ground_projection.sv
// Top level: pipelined pixel-to-ground projection with two restoring dividers.
//
//  channel  | dir | payload
//  ---------+-----+----------------------------------------------------
//  s_axis   | in  | tdata: pixel_u, pixel_v
//  m_axis   | out | tdata: ground_x, ground_y; tuser: invalid
//  cfg      | in  | we, idx, wdata: eight Q16.16 coefficients
//
// One point per clock sustained while m_axis does not stall; stages: multiply, sum,
// sign/overflow prep, 33 divider stages (one quotient bit each), output.
// Reset clears the valid bits and loads the coefficient reset values.
// A stall at m_axis freezes the whole pipe; s_axis_tready follows it.
`include "image_to_ground_projection_defines.svh"

module image_to_ground_projection #(
  parameter int COORD_BITS = igp_pkg::COORD_BITS,
  parameter int FRAC_BITS  = igp_pkg::FRAC_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // [COORD_BITS-1:0] pixel_u, [2*COORD_BITS-1:COORD_BITS] pixel_v, zero fill
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // [31:0] ground_x, [63:32] ground_y
  output logic [63:0] m_axis_tdata_o,
  // [0] invalid
  output logic m_axis_tuser_o,
  input  logic cfg_we_i,
  input  logic [igp_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [igp_pkg::COEF_BITS-1:0] cfg_wdata_i
);

  localparam int CB = igp_pkg::COEF_BITS;
  localparam int PW = CB + COORD_BITS + 1;  // product width
  localparam int NW = PW + 2;               // sum width
  localparam int MW = NW;                   // magnitude width
  localparam int QB = igp_pkg::QUOT_BITS;
  localparam int SH = QB - FRAC_BITS;

  typedef struct packed {
    logic [MW-1:0] ud;
    logic          negx;
    logic          negy;
    logic          ovfx;
    logic          ovfy;
    logic          zero;
  } side_t;

  // Coefficient registers
  logic signed [CB-1:0] cxu_q, cxv_q, cxc_q, cyu_q, cyv_q, cyc_q, cwv_q, cwc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cxu_q <= '0; cxv_q <= '0; cxc_q <= '0;
      cyu_q <= '0; cyv_q <= '0; cyc_q <= '0;
      cwv_q <= '0; cwc_q <= igp_pkg::COEF_W_CONST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        igp_pkg::REG_X_U:     cxu_q <= cfg_wdata_i;
        igp_pkg::REG_X_V:     cxv_q <= cfg_wdata_i;
        igp_pkg::REG_X_CONST: cxc_q <= cfg_wdata_i;
        igp_pkg::REG_Y_U:     cyu_q <= cfg_wdata_i;
        igp_pkg::REG_Y_V:     cyv_q <= cfg_wdata_i;
        igp_pkg::REG_Y_CONST: cyc_q <= cfg_wdata_i;
        igp_pkg::REG_W_V:     cwv_q <= cfg_wdata_i;
        igp_pkg::REG_W_CONST: cwc_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Global advance: the pipe moves unless the output holds a stalled result
  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Stage 1: products
  logic signed [COORD_BITS:0] us, vs;
  logic signed [PW-1:0] pxu_q, pxv_q, pyu_q, pyv_q, pwv_q;
  logic v1_q;

  assign us = $signed({1'b0, s_axis_tdata_i[COORD_BITS-1:0]});
  assign vs = $signed({1'b0, s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxu_q <= cxu_q * us;
      pxv_q <= cxv_q * vs;
      pyu_q <= cyu_q * us;
      pyv_q <= cyv_q * vs;
      pwv_q <= cwv_q * vs;
    end
  end

  // Stage 2: homogeneous sums
  logic signed [NW-1:0] x_q, y_q, w_q;
  logic v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= NW'(pxu_q) + NW'(pxv_q) + NW'(cxc_q);
      y_q <= NW'(pyu_q) + NW'(pyv_q) + NW'(cyc_q);
      w_q <= NW'(pwv_q) + NW'(cwc_q);
    end
  end

  // Stage 3: magnitudes, signs, overflow precheck, divider seed
  logic [MW-1:0] ux, uy, uw;
  assign ux = x_q[NW-1] ? MW'(-x_q) : MW'(x_q);
  assign uy = y_q[NW-1] ? MW'(-y_q) : MW'(y_q);
  assign uw = w_q[NW-1] ? MW'(-w_q) : MW'(w_q);

  logic [QB:0]   vld_q;
  side_t         sd_q [QB+1];
  logic [MW-1:0] rx_q [QB+1];
  logic [MW-1:0] ry_q [QB+1];
  logic [QB-1:0] nx_q [QB+1];
  logic [QB-1:0] ny_q [QB+1];
  logic [QB-1:0] qx_q [QB+1];
  logic [QB-1:0] qy_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (en) vld_q[0] <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0].ud   <= uw;
      sd_q[0].negx <= x_q[NW-1] ^ w_q[NW-1];
      sd_q[0].negy <= y_q[NW-1] ^ w_q[NW-1];
      sd_q[0].ovfx <= (ux >> SH) >= uw;
      sd_q[0].ovfy <= (uy >> SH) >= uw;
      sd_q[0].zero <= (w_q == '0);
      rx_q[0] <= ux >> SH;
      ry_q[0] <= uy >> SH;
      nx_q[0] <= {ux[SH-1:0], {FRAC_BITS{1'b0}}};
      ny_q[0] <= {uy[SH-1:0], {FRAC_BITS{1'b0}}};
      qx_q[0] <= '0;
      qy_q[0] <= '0;
    end
  end

  // Divider stages: one restoring step per stage for x and y
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [MW:0] tx, ty, dd;
    logic        gex, gey;
    assign dd  = {1'b0, sd_q[k].ud};
    assign tx  = {rx_q[k], nx_q[k][QB-1]};
    assign ty  = {ry_q[k], ny_q[k][QB-1]};
    assign gex = tx >= dd;
    assign gey = ty >= dd;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (en) vld_q[k+1] <= vld_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sd_q[k+1] <= sd_q[k];
        rx_q[k+1] <= gex ? MW'(tx - dd) : MW'(tx);
        ry_q[k+1] <= gey ? MW'(ty - dd) : MW'(ty);
        nx_q[k+1] <= {nx_q[k][QB-2:0], 1'b0};
        ny_q[k+1] <= {ny_q[k][QB-2:0], 1'b0};
        qx_q[k+1] <= {qx_q[k][QB-2:0], gex};
        qy_q[k+1] <= {qy_q[k][QB-2:0], gey};
      end
    end
  end

  // Output stage: saturation, sign and zero-divisor handling
  side_t         sf;
  logic [QB-1:0] limx, limy, magx, magy, resx, resy;
  assign sf   = sd_q[QB];
  assign limx = sf.negx ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
  assign limy = sf.negy ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
  assign magx = (sf.ovfx || qx_q[QB] > limx) ? limx : qx_q[QB];
  assign magy = (sf.ovfy || qy_q[QB] > limy) ? limy : qy_q[QB];
  assign resx = sf.negx ? -magx : magx;
  assign resy = sf.negy ? -magy : magy;

  logic [31:0] gx_q, gy_q;
  logic        inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= vld_q[QB];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gx_q  <= sf.zero ? 32'h0 : resx[31:0];
      gy_q  <= sf.zero ? 32'h0 : resy[31:0];
      inv_q <= sf.zero;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {gy_q, gx_q};
  assign m_axis_tuser_o  = inv_q;

  // Checks
  `IGP_ASSERT(a_inv_zero, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 64'h0))
  `IGP_ASSERT(a_ready_rule, clk_i, rst_ni, s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
  `IGP_ASSERT(a_enter, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o) |=> v1_q)
  `IGP_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o)

endmodule
